// ===== design/gsc_pkg.sv =====
// Shared types, widths and fixed-point helpers of the gated recurrent scan cell.
package gsc_pkg;

  localparam int PROJ_W  = 16;
  localparam int SCAN_W  = 24;
  localparam int MIX_W   = 16;
  localparam int ROW_W   = 3;
  localparam int CHAN_W  = 6;
  localparam int SILU_W  = 17;
  localparam int SPLIT_W = 18;

  localparam logic ACT_ELEMENT = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [ROW_W-1:0]         row;
    logic [CHAN_W-1:0]        channel;
    logic signed [PROJ_W-1:0] proj_x;
    logic signed [PROJ_W-1:0] proj_b;
    logic signed [PROJ_W-1:0] proj_c;
    logic signed [PROJ_W-1:0] proj_z;
    logic signed [PROJ_W-1:0] proj_decay;
    logic                     clear_state;
    logic signed [PROJ_W-1:0] bias_value;
    logic signed [PROJ_W-1:0] skip_value;
  } gsc_in_t;

  typedef struct packed {
    logic signed [MIX_W-1:0]  mixed;
    logic signed [SCAN_W-1:0] scan;
    logic [ROW_W-1:0]         out_row;
    logic [CHAN_W-1:0]        out_channel;
  } gsc_out_t;

  // Shift right by s bits, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int s);
    logic [63:0] mag;
    begin
      mag = (v < 0) ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -$signed(mag) : $signed(mag);
    end
  endfunction

  // Clamp a value into the range lo to hi.
  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             input logic signed [63:0] lo,
                                             input logic signed [63:0] hi);
    begin
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    end
  endfunction

  // Piecewise-linear sigmoid with f fraction bits; the result lies in 0 to one.
  function automatic logic signed [63:0] pwl_sigmoid(input logic signed [63:0] v,
                                                     input int f);
    logic signed [63:0] a;
    logic signed [63:0] one;
    logic signed [63:0] y;
    begin
      a   = (v < 0) ? -v : v;
      one = 64'sd1 <<< f;
      if (a >= 64'sd5 * one) begin
        y = one;
      end else if (a >= (64'sd19 <<< (f - 3))) begin
        y = (a >>> 5) + (64'sd27 <<< (f - 5));
      end else if (a >= one) begin
        y = (a >>> 3) + (64'sd5 <<< (f - 3));
      end else begin
        y = (a >>> 2) + (64'sd1 <<< (f - 1));
      end
      return (v < 0) ? one - y : y;
    end
  endfunction

endpackage

// ===== design/gsc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module gsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read in the cycle of a write to the same entry returns the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/gated_recurrent_scan_cell_top.sv =====
// Top level of the gated recurrent scan cell: a seven-stage pipeline around the state RAM.
//
//   Channel   Direction  Payload    Handshake
//   in        input      gsc_in_t   in_valid_i / in_stall_o
//   out       output     gsc_out_t  out_valid_o / out_stall_i
//
// One request is taken every cycle while in_stall_o is low. The state read-modify-write
// closes in stage three, and results of the three stages after it are forwarded, so
// repeated slots back to back are exact. After reset a clearing pass zeroes every
// state RAM entry, with in_stall_o high. A stalled result freezes the whole pipeline;
// nothing is lost.
module gated_recurrent_scan_cell_top
  import gsc_pkg::*;
#(
  parameter int CHANNELS  = 64,
  parameter int ROWS      = 8,
  parameter int FRAC_BITS = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gsc_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gsc_out_t out_res_o
);

  localparam int F       = FRAC_BITS;
  localparam int DEPTH   = ROWS * CHANNELS;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SIG_W   = F + 1;
  localparam int DS_W    = PROJ_W + 1;
  localparam int XP_W    = PROJ_W + SIG_W + 1;
  localparam int NS_W    = SIG_W + SCAN_W + 2;
  localparam int P_W     = SIG_W + SCAN_W + 2;
  localparam int HI_W    = P_W - SPLIT_W;
  localparam int PHI_W   = HI_W + SILU_W;
  localparam int PLO_W   = SPLIT_W + 1 + SILU_W;
  localparam longint RET_MIN  = ((64'sd1 <<< F) + 50) / 100;
  localparam longint RET_MAX  = ((64'sd1 <<< F) * 9999) / 10000;
  localparam longint SCAN_MAX = (64'sd1 <<< (SCAN_W - 1)) - 1;
  localparam longint SCAN_MIN = -(64'sd1 <<< (SCAN_W - 1));
  localparam longint MIX_MAX  = (64'sd1 <<< (MIX_W - 1)) - 1;
  localparam longint MIX_MIN  = -(64'sd1 <<< (MIX_W - 1));

  // Pipeline control.
  logic adv, accept, in_range, elem_in, load_in;
  logic clr_busy_q;
  logic [IDX_W-1:0] clr_cnt_q;
  logic [IDX_W-1:0] idx_in;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = clr_busy_q || !adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(in_req_i.row) < ROWS) && (32'(in_req_i.channel) < CHANNELS);
  assign elem_in    = accept && in_range && (in_req_i.action == ACT_ELEMENT);
  assign load_in    = accept && in_range && (in_req_i.action == ACT_LOAD);
  assign idx_in     = IDX_W'(32'(in_req_i.row) * CHANNELS + 32'(in_req_i.channel));

  // Clearing pass over the state RAM after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Stage registers.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vo_q;
  logic [ROW_W-1:0]  row1_q, row2_q, row3_q, row4_q, row5_q, row6_q;
  logic [CHAN_W-1:0] ch1_q, ch2_q, ch3_q, ch4_q, ch5_q, ch6_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q, idx3_q, idx4_q, idx5_q, idx6_q;
  logic clr1_q, clr2_q, clr3_q;
  logic signed [PROJ_W-1:0] px1_q, pb1_q, pc1_q, pz1_q, pd1_q;
  logic signed [PROJ_W-1:0] px2_q, pz2_q;
  logic [SIG_W-1:0] sx2_q, sz2_q, sb2_q, sc2_q, sb3_q, sc3_q, r3_q, sc4_q;
  logic signed [DS_W-1:0]   ds2_q;
  logic signed [PROJ_W-1:0] skip2_q, skip3_q, skip4_q;
  logic signed [SCAN_W-1:0] st2_q, st3_q;
  logic signed [SILU_W-1:0] x3_q, z3_q, x4_q, z4_q, z5_q;
  logic signed [SCAN_W-1:0] ns4_q, ns5_q, ns6_q;
  logic signed [P_W-1:0]    p5_q;
  logic signed [PHI_W-1:0]  phi6_q;
  logic signed [PLO_W-1:0]  plo6_q;
  gsc_out_t                 res_q;

  // RAM read data, valid in stage one.
  logic signed [SCAN_W-1:0] st_rd;
  logic signed [PROJ_W-1:0] bias_rd, skip_rd;

  // State write port shared by the clearing pass and stage three.
  logic                     st_we;
  logic [IDX_W-1:0]         st_waddr;
  logic signed [SCAN_W-1:0] st_wdata;
  logic signed [SCAN_W-1:0] ns3;

  assign st_we    = clr_busy_q || (adv && v3_q);
  assign st_waddr = clr_busy_q ? clr_cnt_q : idx3_q;
  assign st_wdata = clr_busy_q ? '0 : ns3;

  gsc_ram #(.WIDTH(SCAN_W), .DEPTH(DEPTH)) u_scan_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (adv),
    .raddr_i (idx_in),
    .rdata_o (st_rd)
  );

  gsc_ram #(.WIDTH(PROJ_W), .DEPTH(CHANNELS)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (load_in),
    .waddr_i (CH_W'(in_req_i.channel)),
    .wdata_i (in_req_i.bias_value),
    .re_i    (adv),
    .raddr_i (CH_W'(in_req_i.channel)),
    .rdata_o (bias_rd)
  );

  gsc_ram #(.WIDTH(PROJ_W), .DEPTH(CHANNELS)) u_skip_ram (
    .clk_i   (clk_i),
    .we_i    (load_in),
    .waddr_i (CH_W'(in_req_i.channel)),
    .wdata_i (in_req_i.skip_value),
    .re_i    (adv),
    .raddr_i (CH_W'(in_req_i.channel)),
    .rdata_o (skip_rd)
  );

  // Stage one: the four gate sigmoids and the biased decay logit.
  logic [SIG_W-1:0]       sx1, sz1, sb1, sc1;
  logic signed [DS_W-1:0] ds1;
  always_comb begin
    sx1 = SIG_W'(pwl_sigmoid(64'(px1_q), F));
    sz1 = SIG_W'(pwl_sigmoid(64'(pz1_q), F));
    sb1 = SIG_W'(pwl_sigmoid(64'(pb1_q), F));
    sc1 = SIG_W'(pwl_sigmoid(64'(pc1_q), F));
    ds1 = DS_W'(pd1_q) + DS_W'(bias_rd);
  end

  // Stage two: both silu products and the clamped retention.
  logic signed [XP_W-1:0]   xp2, zp2;
  logic signed [SILU_W-1:0] x2, z2;
  logic [SIG_W-1:0]         r2;
  always_comb begin
    xp2 = px2_q * $signed({1'b0, sx2_q});
    zp2 = pz2_q * $signed({1'b0, sz2_q});
    x2  = SILU_W'(round_shift(64'(xp2), F));
    z2  = SILU_W'(round_shift(64'(zp2), F));
    r2  = SIG_W'(sat(pwl_sigmoid(64'(ds2_q), F), RET_MIN, RET_MAX));
  end

  // Stage three: forward the newest state of the slot, then update it.
  logic signed [SCAN_W-1:0] s3;
  logic signed [NS_W-1:0]   sr3, xb3;
  logic signed [NS_W-1:0]   sum3;
  always_comb begin
    if (v4_q && (idx4_q == idx3_q)) begin
      s3 = ns4_q;
    end else if (v5_q && (idx5_q == idx3_q)) begin
      s3 = ns5_q;
    end else if (v6_q && (idx6_q == idx3_q)) begin
      s3 = ns6_q;
    end else begin
      s3 = st3_q;
    end
    if (clr3_q) begin
      s3 = '0;
    end
    sr3  = s3 * $signed({1'b0, r3_q});
    xb3  = x3_q * $signed({1'b0, sb3_q});
    sum3 = sr3 + xb3;
    ns3  = SCAN_W'(sat(round_shift(64'(sum3), F), SCAN_MIN, SCAN_MAX));
  end

  // Stage four: the output-gated state plus the skip path.
  logic signed [P_W-1:0] nc4, kx4, p4;
  always_comb begin
    nc4 = ns4_q * $signed({1'b0, sc4_q});
    kx4 = skip4_q * x4_q;
    p4  = nc4 + kx4;
  end

  // Stage five: split the sum so that each partial product stays narrow.
  logic signed [PHI_W-1:0] phi5;
  logic signed [PLO_W-1:0] plo5;
  always_comb begin
    phi5 = $signed(p5_q[P_W-1:SPLIT_W]) * z5_q;
    plo5 = $signed({1'b0, p5_q[SPLIT_W-1:0]}) * z5_q;
  end

  // Stage six: combine the partial products, round and saturate.
  logic signed [63:0]      tot6;
  logic signed [MIX_W-1:0] mix6;
  always_comb begin
    tot6 = (64'(phi6_q) <<< SPLIT_W) + 64'(plo6_q);
    mix6 = MIX_W'(sat(round_shift(tot6, 2 * F), MIX_MIN, MIX_MAX));
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= elem_in;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= v6_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      row1_q  <= in_req_i.row;
      ch1_q   <= in_req_i.channel;
      idx1_q  <= idx_in;
      clr1_q  <= in_req_i.clear_state;
      px1_q   <= in_req_i.proj_x;
      pb1_q   <= in_req_i.proj_b;
      pc1_q   <= in_req_i.proj_c;
      pz1_q   <= in_req_i.proj_z;
      pd1_q   <= in_req_i.proj_decay;

      row2_q  <= row1_q;
      ch2_q   <= ch1_q;
      idx2_q  <= idx1_q;
      clr2_q  <= clr1_q;
      px2_q   <= px1_q;
      pz2_q   <= pz1_q;
      sx2_q   <= sx1;
      sz2_q   <= sz1;
      sb2_q   <= sb1;
      sc2_q   <= sc1;
      ds2_q   <= ds1;
      skip2_q <= skip_rd;
      st2_q   <= st_rd;

      row3_q  <= row2_q;
      ch3_q   <= ch2_q;
      idx3_q  <= idx2_q;
      clr3_q  <= clr2_q;
      x3_q    <= x2;
      z3_q    <= z2;
      r3_q    <= r2;
      sb3_q   <= sb2_q;
      sc3_q   <= sc2_q;
      skip3_q <= skip2_q;
      st3_q   <= st2_q;

      row4_q  <= row3_q;
      ch4_q   <= ch3_q;
      idx4_q  <= idx3_q;
      ns4_q   <= ns3;
      x4_q    <= x3_q;
      z4_q    <= z3_q;
      sc4_q   <= sc3_q;
      skip4_q <= skip3_q;

      row5_q  <= row4_q;
      ch5_q   <= ch4_q;
      idx5_q  <= idx4_q;
      ns5_q   <= ns4_q;
      z5_q    <= z4_q;
      p5_q    <= p4;

      row6_q  <= row5_q;
      ch6_q   <= ch5_q;
      idx6_q  <= idx5_q;
      ns6_q   <= ns5_q;
      phi6_q  <= phi5;
      plo6_q  <= plo5;

      res_q.mixed       <= mix6;
      res_q.scan        <= ns6_q;
      res_q.out_row     <= row6_q;
      res_q.out_channel <= ch6_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_res_o   = res_q;

endmodule

// ===== design/gsc_checker.sv =====
// Port-level assertions of the gated recurrent scan cell and their bind to the top level.
module gsc_checker
  import gsc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input gsc_in_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input gsc_out_t out_res_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_res_o))
    else $error("result changed while stalled");

  // A blocked result holds the whole pipeline, so no request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while the output is blocked");

  // The clearing pass holds off requests in the first cycle after reset.
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> in_stall_o)
    else $error("request port open before the state is cleared");

endmodule

bind gated_recurrent_scan_cell_top gsc_checker u_gsc_checker (.*);

// ===== dv/tb_gated_recurrent_scan_cell_top.sv =====
// Self-checking testbench of the gated recurrent scan cell top level.
`timescale 1ns / 100ps

module tb_gated_recurrent_scan_cell_top;
  import gsc_pkg::*;

  localparam int NUM_CH    = 64;
  localparam int NUM_ROWS  = 8;
  localparam int FB        = 12;
  localparam int RANDOM_N  = 830;
  localparam int IDLE_MAX  = 20000;

  localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FB;
  localparam logic signed [63:0] RET_LO  = (ONE_Q + 50) / 100;
  localparam logic signed [63:0] RET_HI  = (ONE_Q * 9999) / 10000;
  localparam logic signed [63:0] SCAN_HI = (64'sd1 <<< 23) - 1;
  localparam logic signed [63:0] SCAN_LO = -(64'sd1 <<< 23);

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  gsc_in_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  gsc_out_t out_res_o;

  gated_recurrent_scan_cell_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  // Shadow copy of the state and weight stores.
  logic signed [23:0] shadow_scan [NUM_ROWS*NUM_CH];
  logic signed [15:0] shadow_bias [NUM_CH];
  logic signed [15:0] shadow_skip [NUM_CH];
  bit                 weights_loaded [NUM_CH];

  gsc_out_t pending_results [$];
  int       error_count;
  int       element_count;
  int       load_count;
  int       checked_count;
  int       idle_cycles;
  bit       timed_out;

  // Directed rows, with an optional result read straight off the math.
  typedef struct {
    gsc_in_t  req;
    bit       has_known;
    gsc_out_t known;
  } directed_row_t;

  directed_row_t directed_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Nearest rounding with ties away from zero.
  function automatic logic signed [63:0] shift_nearest(logic signed [63:0] v, int s);
    logic [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] clamp(logic signed [63:0] v, logic signed [63:0] lo,
                                               logic signed [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Four-segment sigmoid approximation, mirrored for negative inputs.
  function automatic logic signed [63:0] gate_curve(logic signed [63:0] v);
    logic signed [63:0] mag;
    logic signed [63:0] y;
    mag = (v < 0) ? -v : v;
    if (mag >= 5 * ONE_Q) y = ONE_Q;
    else if (mag >= (64'sd19 <<< (FB - 3))) y = (mag >>> 5) + (64'sd27 <<< (FB - 5));
    else if (mag >= ONE_Q) y = (mag >>> 3) + (64'sd5 <<< (FB - 3));
    else y = (mag >>> 2) + (64'sd1 <<< (FB - 1));
    return (v < 0) ? ONE_Q - y : y;
  endfunction

  function automatic logic signed [63:0] swish(logic signed [63:0] v);
    return shift_nearest(v * gate_curve(v), FB);
  endfunction

  // Apply one request to the shadow stores and queue its result, if any.
  task automatic predict_scan_step(gsc_in_t req);
    logic signed [63:0] xv, bv, cv, zv, rv, sv, nv, mv;
    int                 slot;
    gsc_out_t           res;
    if (req.action == ACT_LOAD) begin
      shadow_bias[req.channel] = req.bias_value;
      shadow_skip[req.channel] = req.skip_value;
      weights_loaded[req.channel] = 1'b1;
      load_count++;
    end else begin
      xv = swish(64'(req.proj_x));
      bv = gate_curve(64'(req.proj_b));
      cv = gate_curve(64'(req.proj_c));
      zv = swish(64'(req.proj_z));
      rv = clamp(gate_curve(64'(req.proj_decay) + 64'(shadow_bias[req.channel])),
                 RET_LO, RET_HI);
      slot = req.row * NUM_CH + req.channel;
      sv = req.clear_state ? 64'sd0 : 64'(shadow_scan[slot]);
      nv = clamp(shift_nearest(rv * sv + bv * xv, FB), SCAN_LO, SCAN_HI);
      shadow_scan[slot] = nv[23:0];
      mv = shift_nearest((cv * nv + 64'(shadow_skip[req.channel]) * xv) * zv, 2 * FB);
      mv = clamp(mv, -64'sd32768, 64'sd32767);
      res.mixed       = mv[15:0];
      res.scan        = nv[23:0];
      res.out_row     = req.row;
      res.out_channel = req.channel;
      pending_results = {pending_results, res};
      element_count++;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic gsc_in_t random_element();
    gsc_in_t req;
    int      ch;
    req = '0;
    // Only channels with loaded weights; bias toward a few hot slots.
    do ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_CH - 1)
                                       : $urandom_range(0, 3);
    while (!weights_loaded[ch]);
    req.action      = ACT_ELEMENT;
    req.row         = ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
    req.channel     = 6'(ch);
    // Mostly moderate magnitudes so the segments are all exercised.
    req.proj_x      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 49152)) - 24576);
    req.proj_b      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 49152)) - 24576);
    req.proj_c      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 49152)) - 24576);
    req.proj_z      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 49152)) - 24576);
    req.proj_decay  = 16'($urandom);
    req.clear_state = ($urandom_range(0, 15) == 0);
    req.bias_value  = 16'($urandom);
    req.skip_value  = 16'($urandom);
    return req;
  endfunction

  function automatic gsc_in_t load_request(int ch, logic signed [15:0] bias,
                                           logic signed [15:0] skip);
    gsc_in_t req;
    req = gsc_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    req.action     = ACT_LOAD;
    req.channel    = 6'(ch);
    req.bias_value = bias;
    req.skip_value = skip;
    return req;
  endfunction

  function automatic gsc_in_t element_request(int rw, int ch, logic signed [15:0] v,
                                              bit clr);
    gsc_in_t req;
    req = '0;
    req.action      = ACT_ELEMENT;
    req.row         = 3'(rw);
    req.channel     = 6'(ch);
    req.proj_x      = v;
    req.proj_b      = v;
    req.proj_c      = v;
    req.proj_z      = v;
    req.proj_decay  = v;
    req.clear_state = clr;
    req.bias_value  = ~v;
    req.skip_value  = v;
    return req;
  endfunction

  // Build the directed table.
  task automatic add_row(gsc_in_t req, bit known_ok, gsc_out_t known);
    directed_row_t r;
    r.req = req;
    r.has_known = known_ok;
    r.known = known;
    directed_rows = {directed_rows, r};
  endtask

  task automatic build_directed_table();
    gsc_out_t zero_res;
    zero_res = '0;
    add_row(load_request(0, 16'sd0, 16'sd0), 0, zero_res);
    add_row(load_request(1, 16'sh7fff, 16'sh7fff), 0, zero_res);
    add_row(load_request(2, -16'sd32768, -16'sd32768), 0, zero_res);
    add_row(load_request(63, 16'sd4096, -16'sd4096), 0, zero_res);
    add_row(load_request(3, 16'sd100, 16'sd2048), 0, zero_res);
    // Zero inputs on a fresh slot: every term vanishes.
    zero_res.out_row = 3'd0;
    zero_res.out_channel = 6'd0;
    add_row(element_request(0, 0, 16'sd0, 1'b0), 1, zero_res);
    zero_res.out_row = 3'd7;
    zero_res.out_channel = 6'd63;
    add_row(element_request(7, 63, 16'sd0, 1'b1), 1, zero_res);
    add_row(element_request(7, 63, 16'sh7fff, 1'b0), 0, zero_res);
    add_row(element_request(7, 63, 16'sh7fff, 1'b0), 0, zero_res);
    add_row(element_request(7, 63, -16'sd32768, 1'b0), 0, zero_res);
    add_row(element_request(1, 1, 16'sh7fff, 1'b0), 0, zero_res);
    add_row(element_request(1, 1, 16'sh7fff, 1'b0), 0, zero_res);
    add_row(element_request(2, 2, -16'sd32768, 1'b0), 0, zero_res);
    add_row(element_request(2, 2, -16'sd32768, 1'b1), 0, zero_res);
    // Segment edges of the gate curve.
    add_row(element_request(3, 3, 16'sd4096, 1'b0), 0, zero_res);
    add_row(element_request(3, 3, 16'sd9728, 1'b0), 0, zero_res);
    add_row(element_request(3, 3, 16'sd20480, 1'b0), 0, zero_res);
    add_row(element_request(3, 3, -16'sd4095, 1'b0), 0, zero_res);
    add_row(element_request(3, 3, -16'sd9727, 1'b0), 0, zero_res);
    add_row(element_request(3, 3, -16'sd20479, 1'b1), 0, zero_res);
    // Reload a channel and reuse it right away.
    add_row(load_request(3, -16'sd8000, 16'sh7fff), 0, zero_res);
    add_row(element_request(3, 3, 16'sd12000, 1'b0), 0, zero_res);
    add_row(element_request(5, 3, 16'sd12000, 1'b0), 0, zero_res);
  endtask

  // Sender: bursts of random length, random gaps in between.
  gsc_in_t send_queue [$];
  bit      known_flags [$];
  gsc_out_t known_vals [$];
  bit      stimulus_done;

  initial begin
    int burst;
    int gap;
    gsc_in_t req;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    rst_ni        = 1'b0;
    stimulus_done = 1'b0;
    error_count   = 0;
    for (int i = 0; i < NUM_ROWS * NUM_CH; i++) shadow_scan[i] = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      shadow_bias[i] = '0;
      shadow_skip[i] = '0;
      weights_loaded[i] = 1'b0;
    end
    build_directed_table();
    // Channels loaded by the directed part may be used by the random part.
    foreach (directed_rows[i]) begin
      send_queue = {send_queue, directed_rows[i].req};
      if (directed_rows[i].req.action == ACT_LOAD)
        weights_loaded[directed_rows[i].req.channel] = 1'b1;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed part first, then random mix of loads and elements.
    for (int n = 0; n < RANDOM_N; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        req = load_request($urandom_range(0, NUM_CH - 1), 16'($urandom), 16'($urandom));
        weights_loaded[req.channel] = 1'b1;
      end else begin
        req = random_element();
      end
      send_queue = {send_queue, req};
    end
    // Loads flagged above are replayed by the predictor; reset the flags for accept time.
    for (int i = 0; i < NUM_CH; i++) weights_loaded[i] = 1'b0;
    while (send_queue.size() > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
      while (burst > 0 && send_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        in_req_i   <= send_queue[0];
        @(posedge clk_i);
        if (!in_stall_o) begin
          void'(send_queue.pop_front());
          burst--;
        end
      end
      gap = $urandom_range(0, 4);
      if (gap > 0 && send_queue.size() > 0) begin
        in_valid_i <= 1'b0;
        in_req_i   <= gsc_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver stall pattern: quiet stretches, then runs of random stalls.
  initial begin
    int phase_len;
    int mode;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      phase_len = $urandom_range(10, 80);
      repeat (phase_len) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // Predict on accepted requests, check accepted results, watch for a hang.
  int directed_index;
  initial directed_index = 0;

  always @(posedge clk_i) begin
    gsc_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_scan_step(in_req_i);
        if (directed_index < directed_rows.size()) begin
          if (directed_rows[directed_index].has_known && in_req_i.action == ACT_ELEMENT)
            if (pending_results[$] != directed_rows[directed_index].known)
              report_mismatch("directed expectation scan", pending_results[$].scan,
                              directed_rows[directed_index].known.scan);
          directed_index++;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, channel", out_res_o.out_channel, -1);
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (out_res_o.mixed !== want.mixed)
            report_mismatch("mixed", out_res_o.mixed, want.mixed);
          if (out_res_o.scan !== want.scan)
            report_mismatch("scan", out_res_o.scan, want.scan);
          if (out_res_o.out_row !== want.out_row)
            report_mismatch("out_row", out_res_o.out_row, want.out_row);
          if (out_res_o.out_channel !== want.out_channel)
            report_mismatch("out_channel", out_res_o.out_channel, want.out_channel);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
  end

  // End of run: drain, settle, then give the verdict.
  initial begin
    timed_out = 1'b0;
    checked_count = 0;
    element_count = 0;
    load_count = 0;
    fork
      begin
        wait (stimulus_done && pending_results.size() == 0);
        repeat (30) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= IDLE_MAX);
        timed_out = 1'b1;
      end
    join_any
    $display("Run covered %0d elements and %0d weight loads; %0d results checked.",
             element_count, load_count, checked_count);
    if (timed_out) begin
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end else if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gsc_pkg.sv
design/gsc_ram.sv
design/gated_recurrent_scan_cell_top.sv
design/gsc_checker.sv
dv/tb_gated_recurrent_scan_cell_top.sv
